// ===== src/ip_prefix_table_lpm_top_assert.svh =====
// Assertion macros used by the prefix table controller.
`ifndef IP_PREFIX_TABLE_LPM_TOP_ASSERT_SVH
`define IP_PREFIX_TABLE_LPM_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define IPLPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: ante implies cons");
// Next-cycle implication, checked out of reset.
`define IPLPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: ante implies cons next cycle");
`else
`define IPLPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define IPLPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/iplpm_pkg.sv =====
package iplpm_pkg;

	// Table geometry
	localparam int TableCapacity = 1024;
	localparam int IDX_W = $clog2(TableCapacity);
	localparam int ADDR_W = 32;
	localparam int LEN_W = 6;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

	// Operation codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	// Result codes
	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	// Controller states
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	// One table slot as held in memory
	typedef struct packed {
		logic              valid;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic scan_done;
	} sts_t;

	// Network mask for a prefix length of 0 to 32
	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else begin
			m = {ADDR_W{1'b1}} << (MAX_LEN - len);
		end
		return m;
	endfunction

endpackage

// ===== src/ip_prefix_table_lpm_top.sv =====
// IPv4 prefix table, longest-prefix-match lookup, 1024 slots in one memory.
// After reset a clearing pass writes every slot with in_ready low.
// Per item: a load, then a scan of one slot read per cycle (insert and
// delete stop at the first qualifying slot), then the result.
// A new item is accepted only after the result of the last one has been taken.
// Reset (arst_n, async, active low) clears control state; the clearing pass clears all valid marks.
module ip_prefix_table_lpm_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [iplpm_pkg::ADDR_W-1:0]  address,
	input  logic [iplpm_pkg::LEN_W-1:0]   prefix_len,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [iplpm_pkg::LEN_W-1:0]   match_len
);
	import iplpm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	iplpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Slot memory and compare logic
	iplpm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mode       (mode),
		.address    (address),
		.prefix_len (prefix_len),
		.status     (status),
		.match_len  (match_len)
	);

endmodule

// ===== src/iplpm_ctrl.sv =====
`include "ip_prefix_table_lpm_top_assert.svh"

module iplpm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  iplpm_pkg::sts_t sts,
	output iplpm_pkg::cmd_t cmd
);
	import iplpm_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (sts.clear_last) state_d = S_IDLE;
			S_IDLE:  if (in_valid) state_d = S_SCAN;
			S_SCAN:  if (sts.scan_done) state_d = S_RESP;
			S_RESP:  if (out_ready) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_CLEAR: cmd.clear = 1'b1;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SCAN:  cmd.scan = 1'b1;
			S_RESP:  out_valid = 1'b1;
			default: cmd = '0;
		endcase
	end

	`IPLPM_ASSERT_NEXT(a_accept_scans, clk, arst_n, in_valid && in_ready, state_q == S_SCAN)
	`IPLPM_ASSERT_NEXT(a_done_responds, clk, arst_n, cmd.scan && sts.scan_done, out_valid)
	`IPLPM_ASSERT_IMPLY(a_one_side, clk, arst_n, in_ready, !out_valid && !cmd.scan)

endmodule

// ===== src/iplpm_dp.sv =====
module iplpm_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  iplpm_pkg::cmd_t                cmd,
	output iplpm_pkg::sts_t                sts,
	input  logic [1:0]                     mode,
	input  logic [iplpm_pkg::ADDR_W-1:0]   address,
	input  logic [iplpm_pkg::LEN_W-1:0]    prefix_len,
	output logic [1:0]                     status,
	output logic [iplpm_pkg::LEN_W-1:0]    match_len
);
	import iplpm_pkg::*;

	// Slot memory
	entry_t mem [TableCapacity];

	logic [1:0]        mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  plen_q;
	logic [IDX_W-1:0]  clr_idx_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              issue_done_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	entry_t            rdata_s1;
	logic              hit_q;
	logic [LEN_W-1:0]  best_q;
	logic [1:0]        status_q;
	logic [LEN_W-1:0]  match_len_q;

	logic              issue;
	logic              evalv;
	logic              last;
	logic              ins_hit, del_hit, lk_hit;
	logic              take;
	logic              finish;
	logic              hit_n;
	logic [LEN_W-1:0]  best_n;
	logic              we;
	logic [IDX_W-1:0]  wa;
	entry_t            wd;
	logic [1:0]        status_n;
	logic [LEN_W-1:0]  match_len_n;

	// Slot compare on the registered read data
	always_comb begin
		issue   = cmd.scan && !issue_done_q;
		evalv   = cmd.scan && rd_vld_s1;
		last    = idx_s1 == IDX_W'(TableCapacity - 1);
		ins_hit = !rdata_s1.valid;
		del_hit = rdata_s1.valid && rdata_s1.addr == addr_q && rdata_s1.len == plen_q;
		lk_hit  = rdata_s1.valid &&
			(((addr_q ^ rdata_s1.addr) & len_mask(rdata_s1.len)) == '0);
		case (mode_q)
			MODE_INSERT: take = ins_hit;
			MODE_DELETE: take = del_hit;
			default:     take = 1'b0;
		endcase
		finish = evalv && (take || last);
		hit_n  = hit_q || (evalv && lk_hit);
		best_n = (evalv && lk_hit && rdata_s1.len > best_q) ? rdata_s1.len : best_q;
	end

	// Result of the finished scan
	always_comb begin
		match_len_n = '0;
		case (mode_q)
			MODE_INSERT: status_n = take ? STAT_DONE : STAT_FULL;
			MODE_DELETE: status_n = take ? STAT_DONE : STAT_MISS;
			MODE_LOOKUP: begin
				status_n    = hit_n ? STAT_DONE : STAT_MISS;
				match_len_n = hit_n ? best_n : '0;
			end
			default:     status_n = STAT_MISS;
		endcase
	end

	// Memory write: clearing pass, insert fill or delete
	always_comb begin
		we = cmd.clear || (evalv && take);
		wa = cmd.clear ? clr_idx_q : idx_s1;
		if (cmd.clear) begin
			wd = '0;
		end else if (mode_q == MODE_INSERT) begin
			wd = '{valid: 1'b1, len: plen_q, addr: addr_q};
		end else begin
			wd = '{valid: 1'b0, len: rdata_s1.len, addr: rdata_s1.addr};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_idx_q];
		idx_s1   <= rd_idx_q;
	end

	// Scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q    <= '0;
			rd_idx_q     <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cmd.load) begin
				rd_idx_q     <= '0;
				issue_done_q <= 1'b0;
				rd_vld_s1    <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == IDX_W'(TableCapacity - 1)) begin
						issue_done_q <= 1'b1;
					end
				end
			end
		end
	end

	// Operand capture and lookup accumulation
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			addr_q <= address;
			plen_q <= (prefix_len > MAX_LEN) ? MAX_LEN : prefix_len;
			hit_q  <= 1'b0;
			best_q <= '0;
		end else if (evalv) begin
			hit_q  <= hit_n;
			best_q <= best_n;
		end
		if (finish) begin
			status_q    <= status_n;
			match_len_q <= match_len_n;
		end
	end

	assign sts.clear_last = cmd.clear && clr_idx_q == IDX_W'(TableCapacity - 1);
	assign sts.scan_done  = finish;
	assign status         = status_q;
	assign match_len      = match_len_q;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import iplpm_pkg::*;

	// Unused operation code, treated by the block as a no-op
	localparam logic [1:0] MODE_NOP = 2'd3;

	localparam int RANDOM_ITEMS   = 555;
	localparam int RAND_OCCUPANCY = 48;     // keep the table small during the random phase
	localparam int HOLD_AT        = 150;    // result count at which the receiver holds off
	localparam int HOLD_CYCLES    = 3000;
	localparam int DRAIN_CYCLES   = 1100;   // about one full scan
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int DIR_ROWS       = 25;

	typedef struct packed {
		logic [1:0]       st;
		logic [LEN_W-1:0] mlen;
	} result_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic              known;
		logic [1:0]        st;
		logic [LEN_W-1:0]  mlen;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          mode;
	logic [ADDR_W-1:0]   address;
	logic [LEN_W-1:0]    prefix_len;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic [LEN_W-1:0]    match_len;

	// Shadow copy of the prefix table
	logic [ADDR_W-1:0]   ent_addr [TableCapacity];
	logic [LEN_W-1:0]    ent_len  [TableCapacity];
	logic                ent_used [TableCapacity];
	int                  n_used;

	result_t             pending_results [$];
	dir_row_t            dir_rows [DIR_ROWS];
	int                  fail_cnt = 0;
	int                  tx_calm = 0;
	int                  rx_calm = 0;
	int                  stall_cnt = 0;

	always #2 clk = ~clk;

	ip_prefix_table_lpm_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.address    (address),
		.prefix_len (prefix_len),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.match_len  (match_len)
	);

	// Idle cycles before the next transfer; occasional runs with no idling
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	// Apply one operation to the shadow table and work out its result
	task automatic lpm_apply(input logic [1:0] op, input logic [ADDR_W-1:0] a,
			input logic [LEN_W-1:0] plen, output result_t r);
		logic [LEN_W-1:0]  l;
		logic [ADDR_W-1:0] m;
		int                best;
		r.st = STAT_MISS;
		r.mlen = '0;
		l = (plen > MAX_LEN) ? MAX_LEN : plen;
		case (op)
			MODE_INSERT: begin
				r.st = STAT_FULL;
				for (int k = 0; k < TableCapacity; k++) begin
					if (!ent_used[k]) begin
						ent_addr[k] = a;
						ent_len[k] = l;
						ent_used[k] = 1'b1;
						n_used++;
						r.st = STAT_DONE;
						break;
					end
				end
			end
			MODE_DELETE: begin
				for (int k = 0; k < TableCapacity; k++) begin
					if (ent_used[k] && ent_addr[k] == a && ent_len[k] == l) begin
						ent_used[k] = 1'b0;
						n_used--;
						r.st = STAT_DONE;
						break;
					end
				end
			end
			MODE_LOOKUP: begin
				best = -1;
				for (int k = 0; k < TableCapacity; k++) begin
					if (ent_used[k]) begin
						// shift by 32 gives zero, so length 32 masks nothing off
						m = ~(32'hFFFF_FFFF >> ent_len[k]);
						if ((a & m) == (ent_addr[k] & m) && int'(ent_len[k]) > best)
							best = ent_len[k];
					end
				end
				if (best >= 0) begin
					r.st = STAT_DONE;
					r.mlen = LEN_W'(best);
				end
			end
			default: ;
		endcase
	endtask

	// Index of a random occupied slot; caller makes sure one exists
	function automatic int pick_used();
		int n;
		n = $urandom_range(0, n_used - 1);
		for (int k = 0; k < TableCapacity; k++) begin
			if (ent_used[k]) begin
				if (n == 0)
					return k;
				n--;
			end
		end
		return 0;
	endfunction

	// Offer one item and hold it until the transfer; called at a rising edge
	task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] a,
			input logic [LEN_W-1:0] l, input logic known, input result_t typed);
		int      gap;
		result_t pred;
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		address <= a;
		prefix_len <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		lpm_apply(op, a, l, pred);
		pending_results.push_back(known ? typed : pred);
	endtask

	// Mostly well-formed traffic built around the current table contents
	task automatic make_random_op(output logic [1:0] op, output logic [ADDR_W-1:0] a,
			output logic [LEN_W-1:0] l);
		int                r;
		int                k;
		logic [ADDR_W-1:0] m;
		r = $urandom_range(0, 99);
		a = $urandom;
		l = LEN_W'($urandom_range(8, 32));
		op = MODE_LOOKUP;
		if (r < 5) begin
			// noise: any code, any length
			op = 2'($urandom_range(0, 3));
			l = LEN_W'($urandom_range(0, 63));
		end else if (r < 45 && n_used < RAND_OCCUPANCY) begin
			op = MODE_INSERT;
			case ($urandom_range(0, 9))
				0: l = LEN_W'($urandom_range(0, 7));
				1: l = LEN_W'($urandom_range(33, 63));
				default: ;
			endcase
		end else if (r < 70) begin
			op = MODE_DELETE;
			if (n_used > 0 && $urandom_range(0, 4) != 0) begin
				k = pick_used();
				a = ent_addr[k];
				l = ent_len[k];
				if (l == MAX_LEN && $urandom_range(0, 1) == 1)
					l = LEN_W'($urandom_range(33, 63));
				// near misses: length or one address bit off
				case ($urandom_range(0, 5))
					0: l = l ^ LEN_W'(1);
					1: a = a ^ (32'd1 << $urandom_range(0, 31));
					default: ;
				endcase
			end
		end else begin
			l = LEN_W'($urandom_range(0, 63));
			if (n_used > 0 && $urandom_range(0, 3) != 0) begin
				k = pick_used();
				m = ~(32'hFFFF_FFFF >> ent_len[k]);
				a = (ent_addr[k] & m) | (a & ~m);
			end
		end
	endtask

	// Stimulus
	initial begin
		logic [1:0]        op;
		logic [ADDR_W-1:0] a;
		logic [LEN_W-1:0]  l;
		for (int i = 0; i < TableCapacity; i++)
			ent_used[i] = 1'b0;
		n_used = 0;
		dir_rows = '{
			'{MODE_LOOKUP, 32'h0A00_0001, 6'd0,  1'b1, STAT_MISS, 6'd0},
			'{MODE_DELETE, 32'h0A00_0000, 6'd8,  1'b1, STAT_MISS, 6'd0},
			'{MODE_NOP,    32'hFFFF_FFFF, 6'd63, 1'b1, STAT_MISS, 6'd0},
			'{MODE_INSERT, 32'h0A00_0000, 6'd8,  1'b1, STAT_DONE, 6'd0},
			'{MODE_LOOKUP, 32'h0A12_3456, 6'd63, 1'b1, STAT_DONE, 6'd8},
			'{MODE_INSERT, 32'h0A12_0000, 6'd16, 1'b1, STAT_DONE, 6'd0},
			'{MODE_INSERT, 32'h0A12_3400, 6'd24, 1'b1, STAT_DONE, 6'd0},
			'{MODE_LOOKUP, 32'h0A12_3456, 6'd0,  1'b0, STAT_DONE, 6'd0},
			'{MODE_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b0, STAT_DONE, 6'd0},
			'{MODE_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b0, STAT_DONE, 6'd0},
			// over-long length saturates to 32 on insert and delete
			'{MODE_INSERT, 32'hC0A8_0101, 6'd63, 1'b0, STAT_DONE, 6'd0},
			'{MODE_LOOKUP, 32'hC0A8_0101, 6'd0,  1'b0, STAT_DONE, 6'd0},
			'{MODE_DELETE, 32'hC0A8_0101, 6'd40, 1'b0, STAT_DONE, 6'd0},
			// one-bit prefix: top byte differs but still covered
			'{MODE_INSERT, 32'h8000_0000, 6'd1,  1'b0, STAT_DONE, 6'd0},
			'{MODE_LOOKUP, 32'h9F00_0000, 6'd0,  1'b0, STAT_DONE, 6'd0},
			'{MODE_LOOKUP, 32'h7F00_0000, 6'd0,  1'b0, STAT_DONE, 6'd0},
			// zero-length prefix covers every address
			'{MODE_INSERT, 32'h1234_5678, 6'd0,  1'b0, STAT_DONE, 6'd0},
			'{MODE_LOOKUP, 32'h7F00_0000, 6'd0,  1'b0, STAT_DONE, 6'd0},
			// duplicates: delete removes one copy only
			'{MODE_INSERT, 32'h0A00_0000, 6'd8,  1'b0, STAT_DONE, 6'd0},
			'{MODE_DELETE, 32'h0A00_0000, 6'd8,  1'b0, STAT_DONE, 6'd0},
			'{MODE_LOOKUP, 32'h0A99_0000, 6'd0,  1'b0, STAT_DONE, 6'd0},
			// delete needs exact length and unmasked address
			'{MODE_DELETE, 32'h0A00_0000, 6'd7,  1'b1, STAT_MISS, 6'd0},
			'{MODE_DELETE, 32'h0A00_0001, 6'd8,  1'b1, STAT_MISS, 6'd0},
			'{MODE_INSERT, 32'h0000_0000, 6'd32, 1'b0, STAT_DONE, 6'd0},
			'{MODE_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, STAT_DONE, 6'd0}
		};

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_INSERT;
		address <= '0;
		prefix_len <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].len, dir_rows[i].known,
				'{dir_rows[i].st, dir_rows[i].mlen});

		// sender pause until the block is drained
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);

		// random traffic
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			make_random_op(op, a, l);
			send_item(op, a, l, 1'b0, '0);
		end

		// wait out the last results, then a scan's worth for stray outputs
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Result side: random back-pressure, one long hold, in-order check
	initial begin
		int      gap;
		int      seen;
		result_t want;
		seen = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = (seen == HOLD_AT) ? HOLD_CYCLES : draw_gap(rx_calm);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			seen++;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing pending: status %0d match_len %0d",
					status, match_len);
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					fail_cnt++;
				end
				if (match_len !== want.mlen) begin
					$error("match_len: expected %0d, got %0d", want.mlen, match_len);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
